// ===== src/dgt_pkg.sv =====
`timescale 1ns / 1ps

package dgt_pkg;

  // Fixed field widths and the default table depth.
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned GAP_COUNT_W      = 5;
  localparam int unsigned DEFAULT_MAX_GAPS = 16;

  // Input transaction kinds.
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_FILL   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] range_offset;
    logic [DATA_W-1:0] range_length;
    logic [DATA_W-1:0] expected_offset;
  } in_t;

  typedef struct packed {
    logic                   complete;
    logic [GAP_COUNT_W-1:0] gap_count;
    logic                   table_full;
  } out_t;

  // One stored gap.
  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] size;
  } gap_t;

  // Per-cell control: shift from the right neighbor, or load one of two write ports.
  typedef struct packed {
    logic shift;
    logic wr_lo;
    logic wr_hi;
  } cell_ctrl_t;

  // Outcome of checking the head gap against the received range.
  typedef struct packed {
    logic emit_lo;
    logic emit_hi;
    gap_t lo;
    gap_t hi;
  } cls_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECORD,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

// ===== src/dgt_cell.sv =====
`timescale 1ns / 1ps

module dgt_cell (
  input  logic             clk,
  input  dgt_pkg::cell_ctrl_t ctrl,
  input  dgt_pkg::gap_t    wr_lo_data,
  input  dgt_pkg::gap_t    wr_hi_data,
  input  dgt_pkg::gap_t    from_next,
  output dgt_pkg::gap_t    gap
);
  import dgt_pkg::*;

  // A write to this slot wins over the shift toward the head.
  always_ff @(posedge clk) begin
    if (ctrl.wr_lo) begin
      gap <= wr_lo_data;
    end else if (ctrl.wr_hi) begin
      gap <= wr_hi_data;
    end else if (ctrl.shift) begin
      gap <= from_next;
    end
  end

endmodule

// ===== src/dgt_classify.sv =====
`timescale 1ns / 1ps

module dgt_classify (
  input  dgt_pkg::gap_t              head,
  input  logic [dgt_pkg::DATA_W-1:0] d0,
  input  logic [dgt_pkg::DATA_W:0]   d1,
  output dgt_pkg::cls_t              cls
);
  import dgt_pkg::*;

  logic [DATA_W:0]   g0;
  logic [DATA_W:0]   g1;
  logic [DATA_W:0]   d0x;
  logic [DATA_W:0]   right_size;
  logic [DATA_W-1:0] left_size;

  // Range ends carry one extra bit so that they never wrap.
  assign g0         = {1'b0, head.start};
  assign g1         = g0 + {1'b0, head.size};
  assign d0x        = {1'b0, d0};
  assign right_size = g1 - d1;
  assign left_size  = d0 - head.start;

  // Decide how many pieces of the head gap survive and what they are.
  always_comb begin
    cls.emit_lo = 1'b0;
    cls.emit_hi = 1'b0;
    cls.lo      = head;
    cls.hi      = '{start: d1[DATA_W-1:0], size: right_size[DATA_W-1:0]};
    if (d1 <= g0 || d0x >= g1) begin
      // No overlap: the gap stays as it is.
      cls.emit_lo = 1'b1;
    end else if (d0x <= g0 && d1 >= g1) begin
      // Fully covered: the gap goes away.
      cls.emit_lo = 1'b0;
    end else if (d0x <= g0) begin
      // Covered at its start: shrink from the left.
      cls.emit_lo = 1'b1;
      cls.lo      = '{start: d1[DATA_W-1:0], size: right_size[DATA_W-1:0]};
    end else if (d1 >= g1) begin
      // Covered at its end: shrink from the right.
      cls.emit_lo = 1'b1;
      cls.lo.size = left_size;
    end else begin
      // Data strictly inside: split in two.
      cls.emit_lo = 1'b1;
      cls.emit_hi = 1'b1;
      cls.lo.size = left_size;
    end
  end

endmodule

// ===== src/download_gap_tracker.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data   (dgt_pkg::in_t)
// out       output     out_valid / out_stall out_data (dgt_pkg::out_t)
// cfg       input      cfg_wr_en            cfg_wr_data (log_size)
//
// A record transaction passes through the record and finish states; a fill
// transaction walks once through the n gaps held when it is accepted and then
// finishes, because the gap queue rotates once through the head cell and its
// single range checker, one gap per cycle. The next transaction can be
// accepted once the block is back in idle.
// Reset clears the gap count, the control state and log_size; gap contents
// are not cleared. One transaction is in flight at a time; a result waiting on
// out_stall holds back only the finish of the next transaction.

module download_gap_tracker #(
  parameter int unsigned MAX_GAPS = dgt_pkg::DEFAULT_MAX_GAPS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dgt_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dgt_pkg::out_t              out_data,
  input  logic                       cfg_wr_en,
  input  logic [dgt_pkg::DATA_W-1:0] cfg_wr_data
);
  import dgt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_GAPS + 1);
  localparam int unsigned GW = (CW > GAP_COUNT_W) ? CW : GAP_COUNT_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_GAPS);

  state_t            state;
  state_t            state_next;
  logic [DATA_W-1:0] log_size;
  in_t               item;
  logic [DATA_W:0]   d1;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     rem;
  logic              full;
  logic              full_next;

  logic              in_take;
  logic              walk_step;
  logic              finish;
  logic              rec_write;
  logic              hi_ok;
  logic              over;
  logic [CW-1:0]     count_m1;
  logic [DATA_W-1:0] rec_len;
  logic [GW-1:0]     count_wide;
  gap_t              rec_gap;
  gap_t              lo_data;
  cls_t              cls;
  gap_t              cells [MAX_GAPS];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      log_size <= '0;
    end else if (cfg_wr_en) begin
      log_size <= cfg_wr_data;
    end
  end

  // Record length, saturated so that the gap ends at 2^32 at most.
  assign over     = d1[DATA_W] && (d1[DATA_W-1:0] != '0);
  assign rec_len  = over ? (DATA_W'(0) - item.range_offset) : item.range_length;
  assign rec_gap  = '{start: item.range_offset, size: rec_len};
  assign count_m1 = count - CW'(1);

  // The head cell feeds the range checker.
  dgt_classify u_classify (
    .head (cells[0]),
    .d0   (item.range_offset),
    .d1   (d1),
    .cls  (cls)
  );

  // Control for the current cycle.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    in_take    = 1'b0;
    walk_step  = 1'b0;
    finish     = 1'b0;
    rec_write  = 1'b0;
    hi_ok      = 1'b0;
    count_next = count;
    full_next  = full;
    lo_data    = cls.lo;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        in_take  = in_valid;
        if (in_valid) begin
          full_next  = 1'b0;
          state_next = (in_data.kind == KIND_RECORD) ? ST_RECORD : ST_WALK;
        end
      end
      ST_RECORD: begin
        lo_data = rec_gap;
        if (item.range_length != '0) begin
          if (count < MAX_C) begin
            rec_write  = 1'b1;
            count_next = count + CW'(1);
          end else begin
            full_next = 1'b1;
          end
        end
        state_next = ST_FINISH;
      end
      ST_WALK: begin
        if (rem != '0) begin
          walk_step  = 1'b1;
          hi_ok      = cls.emit_hi && (count < MAX_C);
          count_next = count_m1 + CW'(cls.emit_lo) + CW'(hi_ok);
          if (cls.emit_hi && !(count < MAX_C)) begin
            full_next = 1'b1;
          end
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!(out_valid && out_stall)) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      full  <= 1'b0;
      rem   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      full  <= full_next;
      if (in_take) begin
        rem <= count;
      end else if (walk_step) begin
        rem <= rem - CW'(1);
      end
    end
  end

  // Captured transaction and the end of its range.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= in_data;
      d1   <= {1'b0, in_data.range_offset} + {1'b0, in_data.range_length};
    end
  end

  // Gap queue: the head leaves each walk step, survivors land at the tail.
  for (genvar j = 0; j < MAX_GAPS; j++) begin : g_cell
    cell_ctrl_t ctrl;
    gap_t       from_next;

    if (j == MAX_GAPS - 1) begin : g_last
      assign from_next = '0;
    end else begin : g_mid
      assign from_next = cells[j + 1];
    end

    assign ctrl.shift = walk_step;
    assign ctrl.wr_lo = (walk_step && cls.emit_lo && (count_m1 == CW'(j)))
                        || (rec_write && (count == CW'(j)));
    assign ctrl.wr_hi = walk_step && hi_ok && (count == CW'(j));

    dgt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_lo_data (lo_data),
      .wr_hi_data (cls.hi),
      .from_next  (from_next),
      .gap        (cells[j])
    );
  end

  // Result register.
  assign count_wide = GW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.complete   <= (item.expected_offset >= log_size) && (count == '0);
      out_data.gap_count  <= count_wide[GAP_COUNT_W-1:0];
      out_data.table_full <= full;
    end
  end

  // The queue never holds more gaps than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_C)
    else $error("gap count exceeds table depth");

  // A result appears only out of the finish step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish");

  // Each walk step consumes exactly one original gap.
  a_walk_progress: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && rem != '0) |=> (rem == $past(rem) - CW'(1)))
    else $error("walk counter did not advance");

  // A new transaction is taken only while idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (state == ST_IDLE))
    else $error("transaction accepted while busy");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dgt_pkg::*;

  localparam int unsigned GAP_SLOTS = DEFAULT_MAX_GAPS;

  // A transaction waiting to be sent, optionally held until the block drains.
  typedef struct {
    in_t item;
    bit  hold;
  } pending_txn_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_wr_en = 1'b0;
  logic [DATA_W-1:0] cfg_wr_data = '0;

  pending_txn_t transfer_queue[$];
  out_t         gap_reports_due[$];
  out_t         report_want;
  int unsigned  error_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;

  // Shadow copy of the gap table and the transfer size.
  logic [DATA_W-1:0] hole_start[GAP_SLOTS];
  logic [DATA_W-1:0] hole_len[GAP_SLOTS];
  int unsigned       hole_count = 0;
  logic [DATA_W-1:0] tracked_size = '0;

  download_gap_tracker #(
    .MAX_GAPS(GAP_SLOTS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Updates the shadow table for one transaction and returns the report it should produce.
  function automatic out_t apply_gap_update(in_t t);
    out_t        r;
    logic [32:0] d0;
    logic [32:0] d1;
    logic [32:0] g0;
    logic [32:0] g1;
    logic [32:0] diff;
    int unsigned i;
    int unsigned k;
    logic        dropped;
    dropped = 1'b0;
    if (t.kind == KIND_RECORD) begin
      if (t.range_length != '0) begin
        if (hole_count >= GAP_SLOTS) begin
          dropped = 1'b1;
        end else begin
          // Clip the gap so that it never runs past the top of the address space.
          diff = 33'h1_0000_0000 - {1'b0, t.range_offset};
          hole_start[hole_count] = t.range_offset;
          hole_len[hole_count] = ({1'b0, t.range_length} > diff) ? diff[DATA_W-1:0]
                                                                 : t.range_length;
          hole_count++;
        end
      end
    end else begin
      d0 = {1'b0, t.range_offset};
      d1 = d0 + {1'b0, t.range_length};
      i = 0;
      while (i < hole_count) begin
        g0 = {1'b0, hole_start[i]};
        g1 = g0 + {1'b0, hole_len[i]};
        if (d1 <= g0 || d0 >= g1) begin
          i++;
        end else if (d0 <= g0 && d1 >= g1) begin
          // Fully covered: close up the table over this entry.
          for (k = i; k + 1 < hole_count; k++) begin
            hole_start[k] = hole_start[k+1];
            hole_len[k] = hole_len[k+1];
          end
          hole_count--;
        end else if (d0 <= g0) begin
          diff = g1 - d1;
          hole_start[i] = d1[DATA_W-1:0];
          hole_len[i] = diff[DATA_W-1:0];
          i++;
        end else if (d1 >= g1) begin
          diff = d0 - g0;
          hole_len[i] = diff[DATA_W-1:0];
          i++;
        end else begin
          // Data lands inside the gap: keep the left part, insert the right part after it.
          diff = d0 - g0;
          hole_len[i] = diff[DATA_W-1:0];
          if (hole_count >= GAP_SLOTS) begin
            dropped = 1'b1;
            i++;
          end else begin
            for (k = hole_count; k > i + 1; k--) begin
              hole_start[k] = hole_start[k-1];
              hole_len[k] = hole_len[k-1];
            end
            diff = g1 - d1;
            hole_start[i+1] = d1[DATA_W-1:0];
            hole_len[i+1] = diff[DATA_W-1:0];
            hole_count++;
            i += 2;
          end
        end
      end
    end
    r.complete = (t.expected_offset >= tracked_size) && (hole_count == 0);
    r.gap_count = hole_count[GAP_COUNT_W-1:0];
    r.table_full = dropped;
    return r;
  endfunction

  // Builds one random transaction, mostly gaps and data inside a window above base.
  function automatic in_t random_transfer_item(logic [DATA_W-1:0] base);
    in_t         t;
    int unsigned pick;
    pick = $urandom_range(99);
    t.kind = ($urandom_range(99) < 45) ? KIND_RECORD : KIND_FILL;
    t.range_offset = base + 32'($urandom_range(4095));
    t.range_length = 32'($urandom_range(400, 1));
    if ($urandom_range(1) == 1) begin
      t.expected_offset = tracked_size + 32'($urandom_range(4)) - 32'd2;
    end else begin
      t.expected_offset = $urandom;
    end
    if (pick < 8) begin
      // Noise: every field fully random.
      t.kind = 1'($urandom_range(1));
      t.range_offset = $urandom;
      t.range_length = $urandom;
      t.expected_offset = $urandom;
    end else if (pick < 12) begin
      t.range_length = '0;
    end else if (pick < 15) begin
      // Sweep everything from the window start to the top of the address space.
      t.kind = KIND_FILL;
      t.range_offset = base;
      t.range_length = '1;
    end else if (pick < 17) begin
      t.kind = KIND_FILL;
      t.range_offset = '0;
      t.range_length = '1;
    end
    return t;
  endfunction

  task automatic queue_item(logic kind, logic [DATA_W-1:0] off, logic [DATA_W-1:0] len,
                            logic [DATA_W-1:0] exp_off, bit hold = 1'b0);
    pending_txn_t p;
    p.item.kind = kind;
    p.item.range_offset = off;
    p.item.range_length = len;
    p.item.expected_offset = exp_off;
    p.hold = hold;
    transfer_queue.push_back(p);
  endtask

  // Waits until every queued transaction is sent and every report has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (transfer_queue.size() != 0 || in_valid || gap_reports_due.size() != 0);
  endtask

  task automatic start_phase(int unsigned send_idle, int unsigned stall,
                             logic [DATA_W-1:0] size);
    wait_drained();
    send_idle_pct = send_idle;
    stall_pct = stall;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracked_size = size;
  endtask

  task automatic queue_random(logic [DATA_W-1:0] base, int unsigned count);
    pending_txn_t p;
    repeat (count) begin
      p.item = random_transfer_item(base);
      p.hold = ($urandom_range(49) == 0);
      transfer_queue.push_back(p);
    end
  endtask

  // Driver: presents queued transactions and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        gap_reports_due.push_back(apply_gap_update(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (transfer_queue.size() != 0 &&
            !(transfer_queue[0].hold && gap_reports_due.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_data <= transfer_queue[0].item;
          void'(transfer_queue.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted report against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (gap_reports_due.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Unexpected report: complete=%0b gap_count=%0d table_full=%0b",
                     out_data.complete, out_data.gap_count, out_data.table_full);
          end
        end else begin
          report_want = gap_reports_due.pop_front();
          if (out_data.complete !== report_want.complete ||
              out_data.gap_count !== report_want.gap_count ||
              out_data.table_full !== report_want.table_full) begin
            error_count++;
            if (error_count <= 10) begin
              $display("Mismatch at %0t: expected complete=%0b gap_count=%0d table_full=%0b,",
                       $realtime, report_want.complete, report_want.gap_count,
                       report_want.table_full);
              $display("  got complete=%0b gap_count=%0d table_full=%0b",
                       out_data.complete, out_data.gap_count, out_data.table_full);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the largest transfer size with no idling.
    start_phase(0, 0, 32'hFFFF_FFFF);
    queue_item(KIND_FILL, 32'd0, 32'd10, 32'hFFFF_FFFF);
    queue_item(KIND_RECORD, 32'd50, 32'd0, 32'hFFFF_FFFE);
    for (k = 0; k < 14; k++) begin
      queue_item(KIND_RECORD, k * 1000, 32'd100, 32'd0);
    end
    // Both of these gaps run past the top and get clipped.
    queue_item(KIND_RECORD, 32'hFFFF_FFF0, 32'h100, 32'd0);
    queue_item(KIND_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    queue_item(KIND_RECORD, 32'd7777, 32'd5, 32'd0);
    queue_item(KIND_FILL, 32'd1020, 32'd10, 32'd0, 1'b1);
    queue_item(KIND_FILL, 32'd1990, 32'd20, 32'd0);
    queue_item(KIND_FILL, 32'd3090, 32'd50, 32'd0);
    queue_item(KIND_FILL, 32'd4000, 32'd100, 32'd0);
    queue_item(KIND_FILL, 32'd5050, 32'd0, 32'd0);
    queue_item(KIND_FILL, 32'd5040, 32'd10, 32'd0);
    queue_item(KIND_FILL, 32'd0, 32'hFFFF_FFFF, 32'd0);
    queue_item(KIND_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(32'd0, 120);

    start_phase(72, 0, 32'd0);
    queue_random(32'hFFFF_F000, 130);

    start_phase(0, 72, $urandom);
    queue_random($urandom, 130);

    start_phase(9, 9, 32'd2500);
    queue_random(32'd0, 130);

    start_phase(0, 0, 32'h8000_0000);
    queue_random(32'h7FFF_F800, 140);

    // Let any stray report show up before judging the run.
    wait_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0 && gap_reports_due.size() == 0) begin
      $display("PASS download_gap_tracker");
    end else begin
      $display("FAIL download_gap_tracker");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("FAIL download_gap_tracker");
    $finish;
  end

endmodule
